// ===== src/allm_pkg.sv =====
package allm_pkg;

  localparam int DEF_NUM_SLOTS = 16;

  localparam int REQ_W      = 3;
  localparam int VAL_W      = 31;
  localparam int ST_W       = 2;
  localparam int SLOT_OUT_W = 4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INS_HEAD   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_AFTER  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

endpackage

// ===== src/allm_link_store.sv =====
module allm_link_store #(
  parameter int NUM_SLOTS = allm_pkg::DEF_NUM_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(NUM_SLOTS)-1:0]   rd_addr,
  output logic [$clog2(NUM_SLOTS)-1:0]   rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(NUM_SLOTS)-1:0]   wr_addr,
  input  logic [$clog2(NUM_SLOTS)-1:0]   wr_data,
  input  logic                           clr_en,
  input  logic [$clog2(NUM_SLOTS)-1:0]   clr_addr
);
  import allm_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);

  logic [SW-1:0]        lmem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] lv_r;
  logic [SW-1:0]        rd_raw_r;
  logic                 rd_vld_r;

  // link storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lmem[wr_addr] <= wr_data;
    end
    rd_raw_r <= lmem[rd_addr];
  end

  // per-entry valid; an invalid entry reads as link 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r     <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        lv_r[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        lv_r[clr_addr] <= 1'b0;
      end
      rd_vld_r <= lv_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

// ===== src/array_linked_list_manager.sv =====
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+------------------------------
// request   | in_req_type, in_item_value, in_anchor_value  | taken when start && !busy
// result    | out_status, out_slot_index,                  | out_valid high for one cycle,
//           | out_successor_value, out_is_last             | no back-pressure
//
// One request at a time. Inserts first scan the in-use bits for the lowest free
// slot (one slot per cycle, up to NUM_SLOTS-1 slots), then walk the chain
// through the link memory; each step of the walk waits on a registered
// link/value read. Link updates take one or two writes. The result strobe follows
// in the cycle after the last busy cycle, and a new request can be taken in that
// same cycle. Reset is synchronous, active low; it empties the list at once
// (link valid bits and in-use bits clear). The result receiver cannot stall.
module array_linked_list_manager #(
  parameter int NUM_SLOTS = allm_pkg::DEF_NUM_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [allm_pkg::REQ_W-1:0]        in_req_type,
  input  logic [allm_pkg::VAL_W-1:0]        in_item_value,
  input  logic [allm_pkg::VAL_W-1:0]        in_anchor_value,
  output logic                              out_valid,
  output logic [allm_pkg::ST_W-1:0]         out_status,
  output logic [allm_pkg::SLOT_OUT_W-1:0]   out_slot_index,
  output logic [allm_pkg::VAL_W-1:0]        out_successor_value,
  output logic                              out_is_last
);
  import allm_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;  // free-slot search
  localparam logic [3:0] S_WSTART = 4'd2;  // issue head read
  localparam logic [3:0] S_WLNK   = 4'd3;  // follow link
  localparam logic [3:0] S_WCMP   = 4'd4;  // compare element value
  localparam logic [3:0] S_WR1    = 4'd5;  // fill new slot
  localparam logic [3:0] S_WR2    = 4'd6;  // hook new slot into chain
  localparam logic [3:0] S_SUCC   = 4'd7;  // successor value read back
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [REQ_W-1:0]     type_r, type_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [VAL_W-1:0]     anc_r, anc_nxt;
  logic [SW-1:0]        idx_r, idx_nxt;
  logic [SW-1:0]        f_r, f_nxt;      // new slot
  logic [SW-1:0]        c_r, c_nxt;      // current element
  logic [SW-1:0]        p_r, p_nxt;      // its predecessor
  logic [SW-1:0]        tgt_r, tgt_nxt;  // slot whose link gets the new slot
  logic [SW-1:0]        nxt_r, nxt_nxt;  // link carried by the new slot
  logic [SW:0]          n_r, n_nxt;      // walk step count
  logic [NUM_SLOTS-1:0] inuse_r, inuse_nxt;
  logic [ST_W-1:0]      status_r, status_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [VAL_W-1:0]     succ_r, succ_nxt;
  logic                 last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // value memory (no reset; read only where in use)
  logic [VAL_W-1:0]     vmem [NUM_SLOTS];
  logic [VAL_W-1:0]     val_q;
  logic [SW-1:0]        v_addr;
  logic                 v_we;

  // link store ports
  logic [SW-1:0]        l_addr, l_wdata, l_waddr, l_caddr;
  logic [SW-1:0]        lnk_q;
  logic                 l_we, l_clr;

  logic [VAL_W-1:0]     key;
  logic                 lnk_end;
  logic                 is_ins;

  allm_link_store #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_links (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (l_addr),
    .rd_data  (lnk_q),
    .wr_en    (l_we),
    .wr_addr  (l_waddr),
    .wr_data  (l_wdata),
    .clr_en   (l_clr),
    .clr_addr (l_caddr)
  );

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[f_r] <= val_r;
    end
    val_q <= vmem[v_addr];
  end

  // match key: anchor for positioned inserts, item value otherwise
  assign key     = (type_r == REQ_REMOVE || type_r == REQ_SEARCH) ? val_r : anc_r;
  // link ends the chain: zero or out of range
  assign lnk_end = (lnk_q == '0) || ({1'b0, lnk_q} >= (SW+1)'(NUM_SLOTS));
  assign is_ins  = (type_r == REQ_INS_HEAD) || (type_r == REQ_INS_AFTER) ||
                   (type_r == REQ_INS_BEFORE);

  always_comb begin
    state_nxt     = state_r;
    type_nxt      = type_r;
    val_nxt       = val_r;
    anc_nxt       = anc_r;
    idx_nxt       = idx_r;
    f_nxt         = f_r;
    c_nxt         = c_r;
    p_nxt         = p_r;
    tgt_nxt       = tgt_r;
    nxt_nxt       = nxt_r;
    n_nxt         = n_r;
    inuse_nxt     = inuse_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    succ_nxt      = succ_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    v_addr        = c_r;
    v_we          = 1'b0;
    l_addr        = c_r;
    l_we          = 1'b0;
    l_waddr       = f_r;
    l_wdata       = nxt_r;
    l_clr         = 1'b0;
    l_caddr       = c_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          type_nxt   = in_req_type;
          val_nxt    = in_item_value;
          anc_nxt    = in_anchor_value;
          status_nxt = ST_OK;
          slot_nxt   = '0;
          succ_nxt   = '0;
          last_nxt   = 1'b0;
          n_nxt      = '0;
          p_nxt      = '0;
          idx_nxt    = SW'(1);
          if (in_req_type == REQ_INS_HEAD || in_req_type == REQ_INS_AFTER ||
              in_req_type == REQ_INS_BEFORE) begin
            state_nxt = S_SCAN;
          end else if (in_req_type == REQ_REMOVE || in_req_type == REQ_SEARCH) begin
            state_nxt = S_WSTART;
          end else begin
            status_nxt = ST_NOTFOUND;  // unknown request
            state_nxt  = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (!inuse_r[idx_r]) begin
          f_nxt     = idx_r;
          state_nxt = S_WSTART;
        end else if (idx_r == SW'(NUM_SLOTS - 1)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_WSTART: begin
        l_addr    = '0;
        state_nxt = S_WLNK;
      end

      S_WLNK: begin
        if (type_r == REQ_INS_HEAD) begin
          nxt_nxt   = lnk_q;
          tgt_nxt   = '0;
          state_nxt = S_WR1;
        end else if (lnk_end || n_r == (SW+1)'(NUM_SLOTS)) begin
          if (n_r == '0 && lnk_q == '0 && !is_ins) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_DONE;
        end else begin
          c_nxt     = lnk_q;
          l_addr    = lnk_q;
          v_addr    = lnk_q;
          state_nxt = S_WCMP;
        end
      end

      S_WCMP: begin
        // lnk_q holds link of c, val_q its value
        if (val_q == key) begin
          case (type_r)
            REQ_INS_AFTER: begin
              nxt_nxt   = lnk_q;
              tgt_nxt   = c_r;
              state_nxt = S_WR1;
            end
            REQ_INS_BEFORE: begin
              nxt_nxt   = c_r;
              tgt_nxt   = p_r;
              state_nxt = S_WR1;
            end
            REQ_REMOVE: begin
              l_we           = 1'b1;
              l_waddr        = p_r;
              l_wdata        = lnk_q;
              l_clr          = 1'b1;
              l_caddr        = c_r;
              inuse_nxt[c_r] = 1'b0;
              slot_nxt       = c_r;
              state_nxt      = S_DONE;
            end
            default: begin  // search
              slot_nxt = c_r;
              if (lnk_end) begin
                last_nxt  = 1'b1;
                state_nxt = S_DONE;
              end else begin
                v_addr    = lnk_q;
                state_nxt = S_SUCC;
              end
            end
          endcase
        end else begin
          p_nxt     = c_r;
          n_nxt     = n_r + 1'b1;
          l_addr    = c_r;  // re-present link of c to the follow step
          state_nxt = S_WLNK;
        end
      end

      S_SUCC: begin
        succ_nxt  = val_q;
        state_nxt = S_DONE;
      end

      S_WR1: begin
        l_we           = 1'b1;
        l_waddr        = f_r;
        l_wdata        = nxt_r;
        v_we           = 1'b1;
        inuse_nxt[f_r] = 1'b1;
        state_nxt      = S_WR2;
      end

      S_WR2: begin
        l_we      = 1'b1;
        l_waddr   = tgt_r;
        l_wdata   = f_r;
        slot_nxt  = f_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inuse_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inuse_r     <= inuse_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    type_r   <= type_nxt;
    val_r    <= val_nxt;
    anc_r    <= anc_nxt;
    idx_r    <= idx_nxt;
    f_r      <= f_nxt;
    c_r      <= c_nxt;
    p_r      <= p_nxt;
    tgt_r    <= tgt_nxt;
    nxt_r    <= nxt_nxt;
    n_r      <= n_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    succ_r   <= succ_nxt;
    last_r   <= last_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_slot_index      = SLOT_OUT_W'(slot_r);
  assign out_successor_value = succ_r;
  assign out_is_last         = last_r;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import allm_pkg::*;

  // Sizing: the block is built with its default slot count.
  localparam int SLOTS        = DEF_NUM_SLOTS;
  localparam int TOTAL_REQS   = 850;
  localparam int MAX_SHOWN    = 10;
  // The drain covers more than the longest processing time of one request.
  localparam int DRAIN_CYCLES = 3 * SLOTS + 30;
  localparam int POOL_SIZE    = 12;

  localparam logic [REQ_W-1:0] REQ_CODE_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_MAX      = '1;

  // Fixed values for the directed part.
  localparam logic [VAL_W-1:0] VAL_ALT_A   = 31'h2AAA_AAAA;
  localparam logic [VAL_W-1:0] VAL_ALT_5   = 31'h5555_5555;
  localparam logic [VAL_W-1:0] VAL_ABSENT  = 31'h0000_1234;

  // Operation mix of one random segment.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} seg_mix_t;

  typedef struct {
    logic [REQ_W-1:0] req_kind;
    logic [VAL_W-1:0] item;
    logic [VAL_W-1:0] anchor;
  } list_req_t;

  typedef struct {
    logic [ST_W-1:0]       status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [VAL_W-1:0]      succ;
    logic                  last;
  } list_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  start           = 1'b0;
  logic [REQ_W-1:0]      in_req_type     = '0;
  logic [VAL_W-1:0]      in_item_value   = '0;
  logic [VAL_W-1:0]      in_anchor_value = '0;
  logic                  busy;
  logic                  out_valid;
  logic [ST_W-1:0]       out_status;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic [VAL_W-1:0]      out_successor_value;
  logic                  out_is_last;

  always #5 clk = ~clk;

  array_linked_list_manager u_dut (
    .clk,
    .rst_n,
    .start,
    .busy,
    .in_req_type,
    .in_item_value,
    .in_anchor_value,
    .out_valid,
    .out_status,
    .out_slot_index,
    .out_successor_value,
    .out_is_last
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  list_req_t    pending_reqs[$];     // requests not yet offered to the DUT
  list_result_t expected_results[$]; // predictions waiting for their result

  // Shadow of the list: values, next links and in-use flags per slot.
  logic [VAL_W-1:0]      shadow_val  [SLOTS];
  logic [SLOT_OUT_W-1:0] shadow_next [SLOTS];
  logic                  shadow_used [SLOTS];

  logic [VAL_W-1:0] value_pool[POOL_SIZE];

  bit req_taken    = 1'b0;  // request handshake completed at the last rising edge
  int results_seen = 0;
  int reqs_taken   = 0;
  int mismatches   = 0;
  int status_count[4];

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // First element in list order holding v; 0 if none. pred gets its predecessor.
  // The step bound only guards against a broken chain.
  function automatic int find_value(logic [VAL_W-1:0] v, output int pred);
    int p;
    int c;
    p    = 0;
    c    = shadow_next[0];
    pred = 0;
    for (int n = 0; n < SLOTS && c != 0; n++) begin
      if (shadow_val[c] == v) begin
        pred = p;
        return c;
      end
      p = c;
      c = shadow_next[c];
    end
    return 0;
  endfunction

  // Splice slot f holding v in right after slot p.
  function automatic void link_in(int p, int f, logic [VAL_W-1:0] v);
    shadow_next[f] = shadow_next[p];
    shadow_next[p] = SLOT_OUT_W'(f);
    shadow_val[f]  = v;
    shadow_used[f] = 1'b1;
  endfunction

  // Applies one request to the shadow list and returns the result it must give.
  function automatic list_result_t predict_request(list_req_t r);
    list_result_t res;
    int free_slot;
    int hit;
    int pred;
    res = '{ST_OK, '0, '0, 1'b0};
    case (r.req_kind)
      REQ_INS_HEAD, REQ_INS_AFTER, REQ_INS_BEFORE: begin
        // lowest free slot; fullness wins over a missing anchor
        free_slot = 0;
        for (int s = SLOTS - 1; s >= 1; s--)
          if (!shadow_used[s]) free_slot = s;
        if (free_slot == 0) begin
          res.status = ST_FULL;
        end else if (r.req_kind == REQ_INS_HEAD) begin
          link_in(0, free_slot, r.item);
          res.slot = SLOT_OUT_W'(free_slot);
        end else begin
          hit = find_value(r.anchor, pred);
          if (hit == 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            link_in((r.req_kind == REQ_INS_AFTER) ? hit : pred, free_slot, r.item);
            res.slot = SLOT_OUT_W'(free_slot);
          end
        end
      end
      REQ_REMOVE, REQ_SEARCH: begin
        if (shadow_next[0] == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit = find_value(r.item, pred);
          if (hit == 0) begin
            res.status = ST_NOTFOUND;
          end else if (r.req_kind == REQ_REMOVE) begin
            shadow_next[pred] = shadow_next[hit];
            shadow_next[hit]  = '0;
            shadow_used[hit]  = 1'b0;
            res.slot = SLOT_OUT_W'(hit);
          end else begin
            res.slot = SLOT_OUT_W'(hit);
            if (shadow_next[hit] == 0) res.last = 1'b1;
            else                       res.succ = shadow_val[shadow_next[hit]];
          end
        end
      end
      default: begin
        // unknown request type: no state change, not-found with zero fields
        res.status = ST_NOTFOUND;
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [REQ_W-1:0] k, logic [VAL_W-1:0] v, logic [VAL_W-1:0] a);
    pending_reqs.push_back('{k, v, a});
  endtask

  // Mostly values from a small pool so removes, searches and anchors hit;
  // now and then a fresh full-range value.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 85)
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return VAL_W'($urandom);
  endfunction

  task automatic flag_mismatch(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. Sends in bursts with gaps,
  // gap lengths spread over the whole processing time of a request.
  // ---------------------------------------------------------------------------
  int        burst_left = 0;
  int        gap_left   = 0;
  list_req_t next_req;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // request still waiting for !busy: hold everything
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pending_reqs.size() != 0) begin
      next_req = pending_reqs.pop_front();
      start           <= 1'b1;
      in_req_type     <= next_req.req_kind;
      in_item_value   <= next_req.item;
      in_anchor_value <= next_req.anchor;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 12);
        // a third of the bursts run back to back with no gap after them
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3 * SLOTS + 10);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples on the rising edge. Checks each result strobe against the
  // oldest prediction, then records a request accepted at this edge and
  // predicts its result.
  // ---------------------------------------------------------------------------
  list_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        shadow_val[s]  = '0;
        shadow_next[s] = '0;
        shadow_used[s] = 1'b0;
      end
      req_taken = 1'b0;
    end else begin
      if (out_valid) begin
        results_seen++;
        status_count[out_status]++;
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no request outstanding", '0, VAL_W'(out_status));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", VAL_W'(want.status), VAL_W'(out_status));
          if (out_slot_index !== want.slot)
            flag_mismatch("slot_index", VAL_W'(want.slot), VAL_W'(out_slot_index));
          if (out_successor_value !== want.succ)
            flag_mismatch("successor_value", want.succ, out_successor_value);
          if (out_is_last !== want.last)
            flag_mismatch("is_last", VAL_W'(want.last), VAL_W'(out_is_last));
        end
      end
      req_taken = start && !busy;
      if (req_taken) begin
        reqs_taken++;
        expected_results.push_back(
          predict_request('{in_req_type, in_item_value, in_anchor_value}));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  seg_mix_t seg_mix;
  int       seg_len;
  int       roll;
  logic [REQ_W-1:0] pick_kind;

  initial begin
    value_pool[0] = '0;
    value_pool[1] = VAL_MAX;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = VAL_W'($urandom);

    // Empty list: searches and removes see it empty, anchored inserts miss.
    push_req(REQ_SEARCH,     31'd5,   '0);
    push_req(REQ_REMOVE,     VAL_MAX, '0);
    push_req(REQ_INS_AFTER,  31'd7,   '0);
    push_req(REQ_INS_BEFORE, 31'd7,   VAL_MAX);
    // unknown request types, lowest and highest code
    push_req(REQ_W'(REQ_SEARCH + 1), VAL_MAX, VAL_MAX);
    push_req(REQ_CODE_MAX,   VAL_MAX, VAL_MAX);
    // build up: extremes, insert after, insert before the head, a duplicate
    push_req(REQ_INS_HEAD,   '0,        '0);
    push_req(REQ_INS_HEAD,   VAL_MAX,   '0);
    push_req(REQ_INS_AFTER,  VAL_ALT_A, '0);
    push_req(REQ_INS_BEFORE, VAL_ALT_5, VAL_MAX);
    push_req(REQ_INS_HEAD,   '0,        VAL_MAX);
    // searches: middle element, tail element, duplicate (first in order wins)
    push_req(REQ_SEARCH, VAL_MAX,   '0);
    push_req(REQ_SEARCH, VAL_ALT_A, '0);
    push_req(REQ_SEARCH, '0,        '0);
    // remove first duplicate, remove a missing value, anchor missing on a live list
    push_req(REQ_REMOVE,    '0,         '0);
    push_req(REQ_REMOVE,    VAL_ABSENT, '0);
    push_req(REQ_INS_AFTER, 31'd9,      VAL_ABSENT);
    // fill to the last slot (reuses the hole left by the remove)
    for (int i = 0; i < SLOTS - 5; i++)
      push_req((i % 2) ? REQ_INS_HEAD : REQ_INS_BEFORE, VAL_W'($urandom), VAL_ALT_A);
    // full list: fullness reported even where the anchor is missing
    push_req(REQ_INS_AFTER, 31'd1, VAL_ABSENT);
    push_req(REQ_INS_HEAD,  31'd2, '0);

    // Random part: segments biased toward filling, draining or a balance, so
    // the list swings between empty and full. A few percent are unknown types.
    while (pending_reqs.size() < TOTAL_REQS) begin
      seg_mix = seg_mix_t'($urandom_range(MIX_FILL, MIX_BALANCED));
      seg_len = $urandom_range(10, 50);
      value_pool[$urandom_range(2, POOL_SIZE - 1)] = VAL_W'($urandom);
      for (int i = 0; i < seg_len && pending_reqs.size() < TOTAL_REQS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          push_req(REQ_W'($urandom_range(REQ_SEARCH + 1, REQ_CODE_MAX)),
                   pick_value(), pick_value());
        end else begin
          roll = $urandom_range(0, 99);
          case (seg_mix)
            MIX_FILL:  pick_kind = (roll < 75) ? REQ_INS_HEAD :
                                   (roll < 85) ? REQ_REMOVE : REQ_SEARCH;
            MIX_DRAIN: pick_kind = (roll < 15) ? REQ_INS_HEAD :
                                   (roll < 75) ? REQ_REMOVE : REQ_SEARCH;
            default:   pick_kind = (roll < 40) ? REQ_INS_HEAD :
                                   (roll < 65) ? REQ_REMOVE : REQ_SEARCH;
          endcase
          // spread inserts evenly over the three insert kinds
          if (pick_kind == REQ_INS_HEAD)
            pick_kind = REQ_W'($urandom_range(REQ_INS_HEAD, REQ_INS_BEFORE));
          push_req(pick_kind, pick_value(), pick_value());
        end
      end
    end

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // every request gives exactly one result
    while (results_seen < TOTAL_REQS) @(posedge clk);
    // let any stray late strobe show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d predicted results never arrived", expected_results.size());
    end

    $display("Ran %0d requests, %0d results: ok %0d, full %0d, not found %0d, empty %0d",
             reqs_taken, results_seen, status_count[ST_OK], status_count[ST_FULL],
             status_count[ST_NOTFOUND], status_count[ST_EMPTY]);
    $display("Mismatching fields: %0d", mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs before all results are seen.
  initial begin
    #10_000_000;
    $display("Timeout: %0d of %0d results seen", results_seen, TOTAL_REQS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
